@@ sv/mcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_pkg: shared types and constants of the convolution engine
// Holds the field widths, request and register codes, controller states and
// the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mcc_pkg;

	localparam int REQ_W      = 2;
	localparam int IDX_W      = 6;
	localparam int PLANE_W    = 4;
	localparam int SHORT_W    = 16;
	localparam int BIAS_W     = 32;
	localparam int PROD_W     = 32;
	localparam int SUM_W      = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;
	localparam int SIZE_W     = 7;   // in_height, in_width, strides
	localparam int KSIZE_W    = 4;   // kernel_height, kernel_width
	localparam int COUNT_W    = 5;   // plane counts
	localparam int SPAN_W     = 14;  // stride * index + kernel size

	// request codes
	localparam logic [REQ_W-1:0] REQ_SAMPLE  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_WEIGHT  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_BIAS    = 2'd2;
	localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_ROWS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_COLS   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_IN_PLANES     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_PLANES    = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RUN,
		ST_DRAIN,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic capture;   // latch the request beat
		logic write_en;  // commit a load that passed the range check
		logic start;     // clear tap counters, fetch bias
		logic step;      // issue one tap read, advance counters
		logic resp;      // load the result register
	} cmd_t;

	typedef struct packed {
		logic bad;
		logic is_compute;
		logic last_tap;
		logic pipe_busy;
		logic out_free;
	} sts_t;

endpackage

@@ sv/mcc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_if: channel interfaces of the convolution engine
// Request channel, result channel and configuration write channel, each a
// valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface mcc_req_if;
	import mcc_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [REQ_W-1:0]          req_type;
	logic [IDX_W-1:0]          row_index;
	logic [IDX_W-1:0]          col_index;
	logic [PLANE_W-1:0]        src_plane;
	logic [PLANE_W-1:0]        dst_plane;
	logic signed [SHORT_W-1:0] short_value;
	logic signed [BIAS_W-1:0]  bias_value;

	modport source (output valid, req_type, row_index, col_index, src_plane, dst_plane,
		short_value, bias_value, input ready);
	modport sink (input valid, req_type, row_index, col_index, src_plane, dst_plane,
		short_value, bias_value, output ready);
endinterface

interface mcc_rsp_if;
	import mcc_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [SUM_W-1:0] conv_sum;
	logic                    status;

	modport source (output valid, conv_sum, status, input ready);
	modport sink (input valid, conv_sum, status, output ready);
endinterface

interface mcc_cfg_if;
	import mcc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ sv/mcc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mcc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/mcc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_ctrl: request sequencer
// Takes one request at a time, has it range checked, runs the tap loop for
// compute requests and hands the result to the output register.
// ----------------------------------------------------------------------------
module mcc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  mcc_pkg::sts_t sts,
	output mcc_pkg::cmd_t cmd
);
	import mcc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.is_compute && !sts.bad) begin
					cmd.start = 1'b1;
					state_d   = ST_RUN;
				end else begin
					cmd.write_en = 1'b1;
					state_d      = ST_RESP;
				end
			end
			ST_RUN: begin
				cmd.step = 1'b1;
				if (sts.last_tap) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// wait for the read and multiply stages to empty
				if (!sts.pipe_busy) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.resp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ sv/mcc_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_dp: convolution datapath
// Configuration registers, range checks, sample/weight/bias stores, tap
// counters, the read-multiply-accumulate pipeline and the result register.
// ----------------------------------------------------------------------------
module mcc_dp #(
	parameter int MAX_ROWS        = 64,
	parameter int MAX_COLS        = 64,
	parameter int MAX_KERNEL_ROWS = 8,
	parameter int MAX_KERNEL_COLS = 8,
	parameter int MAX_IN_PLANES   = 16,
	parameter int MAX_OUT_PLANES  = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	mcc_req_if.sink       req,
	mcc_rsp_if.source     rsp,
	mcc_cfg_if.sink       cfg,
	input  mcc_pkg::cmd_t cmd,
	output mcc_pkg::sts_t sts
);
	import mcc_pkg::*;

	localparam int SAMPLE_DEPTH = MAX_IN_PLANES * MAX_ROWS * MAX_COLS;
	localparam int WEIGHT_DEPTH = MAX_OUT_PLANES * MAX_IN_PLANES * MAX_KERNEL_ROWS
		* MAX_KERNEL_COLS;
	localparam int SA_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
	localparam int WA_W = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
	localparam int BA_W = (MAX_OUT_PLANES > 1) ? $clog2(MAX_OUT_PLANES) : 1;

	function automatic logic [SIZE_W-1:0] sat(input logic [SIZE_W-1:0] v, input int hi);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (int'(v) > hi) begin
			r = SIZE_W'(hi);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// configuration
	logic [SIZE_W-1:0]  in_height_q, in_width_q, stride_rows_q, stride_cols_q;
	logic [KSIZE_W-1:0] kernel_height_q, kernel_width_q;
	logic [COUNT_W-1:0] in_planes_q, out_planes_q;

	// captured request
	logic [REQ_W-1:0]          req_type_q;
	logic [IDX_W-1:0]          row_q, col_q;
	logic [PLANE_W-1:0]        src_q, dst_q;
	logic [SHORT_W-1:0]        short_q;
	logic [BIAS_W-1:0]         bias_q;

	// effective sizes
	logic [SIZE_W-1:0]  h_eff, w_eff, dr_eff, dc_eff;
	logic [KSIZE_W-1:0] kh_eff, kw_eff;
	logic [COUNT_W-1:0] np_eff, nq_eff;
	logic [SPAN_W-1:0]  row_base, col_base;
	logic               bad, is_compute;

	// tap loop
	logic [COUNT_W-1:0] p_q;
	logic [KSIZE_W-1:0] s_q, t_q;
	logic [SPAN_W-1:0]  base_row_q, base_col_q;
	logic               tap_last_p, tap_last_s, tap_last_t;

	// stores
	logic               sample_we, weight_we, bias_we;
	logic [SA_W-1:0]    sample_waddr, sample_raddr;
	logic [WA_W-1:0]    weight_waddr, weight_raddr;
	logic [BA_W-1:0]    bias_addr;
	logic [SHORT_W-1:0] sample_rd, weight_rd;
	logic [BIAS_W-1:0]  bias_rd;

	// pipeline
	logic                     bias_vld_s1, tap_vld_s1, prod_vld_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [SUM_W-1:0]  acc_q;
	logic                     out_vld_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_height_q     <= SIZE_W'(1);
			in_width_q      <= SIZE_W'(1);
			kernel_height_q <= KSIZE_W'(1);
			kernel_width_q  <= KSIZE_W'(1);
			stride_rows_q   <= SIZE_W'(1);
			stride_cols_q   <= SIZE_W'(1);
			in_planes_q     <= COUNT_W'(1);
			out_planes_q    <= COUNT_W'(1);
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_IN_HEIGHT:     in_height_q     <= cfg.data;
				CFG_IN_WIDTH:      in_width_q      <= cfg.data;
				CFG_KERNEL_HEIGHT: kernel_height_q <= cfg.data[KSIZE_W-1:0];
				CFG_KERNEL_WIDTH:  kernel_width_q  <= cfg.data[KSIZE_W-1:0];
				CFG_STRIDE_ROWS:   stride_rows_q   <= cfg.data;
				CFG_STRIDE_COLS:   stride_cols_q   <= cfg.data;
				CFG_IN_PLANES:     in_planes_q     <= cfg.data[COUNT_W-1:0];
				CFG_OUT_PLANES:    out_planes_q    <= cfg.data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_type_q <= req.req_type;
			row_q      <= req.row_index;
			col_q      <= req.col_index;
			src_q      <= req.src_plane;
			dst_q      <= req.dst_plane;
			short_q    <= req.short_value;
			bias_q     <= req.bias_value;
		end
	end

	assign h_eff  = sat(in_height_q, MAX_ROWS);
	assign w_eff  = sat(in_width_q, MAX_COLS);
	assign kh_eff = KSIZE_W'(sat(SIZE_W'(kernel_height_q), MAX_KERNEL_ROWS));
	assign kw_eff = KSIZE_W'(sat(SIZE_W'(kernel_width_q), MAX_KERNEL_COLS));
	assign dr_eff = (stride_rows_q == '0) ? SIZE_W'(1) : stride_rows_q;
	assign dc_eff = (stride_cols_q == '0) ? SIZE_W'(1) : stride_cols_q;
	assign np_eff = COUNT_W'(sat(SIZE_W'(in_planes_q), MAX_IN_PLANES));
	assign nq_eff = COUNT_W'(sat(SIZE_W'(out_planes_q), MAX_OUT_PLANES));

	assign row_base = SPAN_W'(dr_eff) * SPAN_W'(row_q);
	assign col_base = SPAN_W'(dc_eff) * SPAN_W'(col_q);

	// output row r exists when stride*r + kernel rows still fits the plane
	always_comb begin
		is_compute = 1'b0;
		case (req_type_q)
			REQ_SAMPLE: begin
				bad = (SIZE_W'(row_q) >= h_eff) || (SIZE_W'(col_q) >= w_eff)
					|| (COUNT_W'(src_q) >= np_eff);
			end
			REQ_WEIGHT: begin
				bad = (SIZE_W'(row_q) >= SIZE_W'(kh_eff)) || (SIZE_W'(col_q) >= SIZE_W'(kw_eff))
					|| (COUNT_W'(src_q) >= np_eff) || (COUNT_W'(dst_q) >= nq_eff);
			end
			REQ_BIAS: begin
				bad = COUNT_W'(dst_q) >= nq_eff;
			end
			REQ_COMPUTE: begin
				is_compute = 1'b1;
				bad = (row_base + SPAN_W'(kh_eff) > SPAN_W'(h_eff))
					|| (col_base + SPAN_W'(kw_eff) > SPAN_W'(w_eff))
					|| (COUNT_W'(dst_q) >= nq_eff);
			end
			default: begin
				bad = 1'b1;
			end
		endcase
	end

	// tap counters: columns fastest, then kernel rows, then planes
	assign tap_last_t = (t_q == kw_eff - KSIZE_W'(1));
	assign tap_last_s = (s_q == kh_eff - KSIZE_W'(1));
	assign tap_last_p = (p_q == np_eff - COUNT_W'(1));

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			p_q        <= '0;
			s_q        <= '0;
			t_q        <= '0;
			base_row_q <= row_base;
			base_col_q <= col_base;
		end else if (cmd.step) begin
			if (tap_last_t) begin
				t_q <= '0;
				if (tap_last_s) begin
					s_q <= '0;
					p_q <= p_q + COUNT_W'(1);
				end else begin
					s_q <= s_q + KSIZE_W'(1);
				end
			end else begin
				t_q <= t_q + KSIZE_W'(1);
			end
		end
	end

	// store addressing
	assign sample_we = cmd.write_en && !bad && (req_type_q == REQ_SAMPLE);
	assign weight_we = cmd.write_en && !bad && (req_type_q == REQ_WEIGHT);
	assign bias_we   = cmd.write_en && !bad && (req_type_q == REQ_BIAS);

	assign sample_waddr = SA_W'((int'(src_q) * MAX_ROWS + int'(row_q)) * MAX_COLS
		+ int'(col_q));
	assign sample_raddr = SA_W'((int'(p_q) * MAX_ROWS + int'(base_row_q) + int'(s_q))
		* MAX_COLS + int'(base_col_q) + int'(t_q));
	assign weight_waddr = WA_W'(((int'(dst_q) * MAX_IN_PLANES + int'(src_q))
		* MAX_KERNEL_ROWS + int'(row_q)) * MAX_KERNEL_COLS + int'(col_q));
	assign weight_raddr = WA_W'(((int'(dst_q) * MAX_IN_PLANES + int'(p_q))
		* MAX_KERNEL_ROWS + int'(s_q)) * MAX_KERNEL_COLS + int'(t_q));
	assign bias_addr    = BA_W'(dst_q);

	mcc_ram #(.WIDTH(SHORT_W), .DEPTH(SAMPLE_DEPTH)) u_sample_ram (
		.clk   (clk),
		.we    (sample_we),
		.waddr (sample_waddr),
		.wdata (short_q),
		.raddr (sample_raddr),
		.rdata (sample_rd)
	);

	mcc_ram #(.WIDTH(SHORT_W), .DEPTH(WEIGHT_DEPTH)) u_weight_ram (
		.clk   (clk),
		.we    (weight_we),
		.waddr (weight_waddr),
		.wdata (short_q),
		.raddr (weight_raddr),
		.rdata (weight_rd)
	);

	mcc_ram #(.WIDTH(BIAS_W), .DEPTH(MAX_OUT_PLANES)) u_bias_ram (
		.clk   (clk),
		.we    (bias_we),
		.waddr (bias_addr),
		.wdata (bias_q),
		.raddr (bias_addr),
		.rdata (bias_rd)
	);

	// read -> multiply -> accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_vld_s1 <= 1'b0;
			tap_vld_s1  <= 1'b0;
			prod_vld_s2 <= 1'b0;
		end else begin
			bias_vld_s1 <= cmd.start;
			tap_vld_s1  <= cmd.step;
			prod_vld_s2 <= tap_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (tap_vld_s1) begin
			prod_s2 <= PROD_W'($signed(weight_rd)) * PROD_W'($signed(sample_rd));
		end
		if (bias_vld_s1) begin
			acc_q <= SUM_W'($signed(bias_rd));
		end else if (prod_vld_s2) begin
			acc_q <= acc_q + SUM_W'(prod_s2);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.resp) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resp) begin
			rsp.conv_sum <= (is_compute && !bad) ? acc_q : '0;
			rsp.status   <= bad;
		end
	end

	assign rsp.valid = out_vld_q;

	assign sts.bad        = bad;
	assign sts.is_compute = is_compute;
	assign sts.last_tap   = tap_last_t && tap_last_s && tap_last_p;
	assign sts.pipe_busy  = tap_vld_s1 || prod_vld_s2;
	assign sts.out_free   = !out_vld_q || rsp.ready;

endmodule

@@ sv/multichannel_conv2d_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_conv2d_engine: strided multi-plane 2D convolution engine
// Fixed-point valid convolution: Q8.8 samples and weights, Q16.16 bias,
// Q32.16 result.
// ----------------------------------------------------------------------------
// Usage:
//   req  - request beats: load a sample, weight or bias, or compute one output.
//   rsp  - one result beat per request: conv_sum and status (1 = index out of
//          the configured range, nothing done, conv_sum zero).
//   cfg  - register writes (index, data); always ready, write only while idle.
// Timing: one request is in flight at a time. A load passes the check state
//   on its way to the result register. A compute runs one multiply-accumulate
//   per cycle over planes * kernel rows * kernel cols taps, paced by the
//   single read port of the sample and weight stores, then drains the read
//   and multiply stages before the result register is loaded.
// The result register parts the two sides: a new request is accepted while a
//   result waits; a stalled receiver holds the result and, once the next
//   result is ready, holds the engine until the register frees.
// Reset: registers return to 1, the sequencer goes idle, no result pending.
//   Store contents are undefined until written; there is no clearing pass.
// ----------------------------------------------------------------------------
module multichannel_conv2d_engine #(
	parameter int MAX_ROWS        = 64,
	parameter int MAX_COLS        = 64,
	parameter int MAX_KERNEL_ROWS = 8,
	parameter int MAX_KERNEL_COLS = 8,
	parameter int MAX_IN_PLANES   = 16,
	parameter int MAX_OUT_PLANES  = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	mcc_req_if.sink   req,
	mcc_rsp_if.source rsp,
	mcc_cfg_if.sink   cfg
);
	import mcc_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic req_ready;

	assign req.ready = req_ready;

	mcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mcc_dp #(
		.MAX_ROWS        (MAX_ROWS),
		.MAX_COLS        (MAX_COLS),
		.MAX_KERNEL_ROWS (MAX_KERNEL_ROWS),
		.MAX_KERNEL_COLS (MAX_KERNEL_COLS),
		.MAX_IN_PLANES   (MAX_IN_PLANES),
		.MAX_OUT_PLANES  (MAX_OUT_PLANES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

@@ sv/mcc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_checker: port-level checks for the convolution engine
// Watches the request and result handshakes of the top level.
// ----------------------------------------------------------------------------
module mcc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic signed [mcc_pkg::SUM_W-1:0] conv_sum,
	input logic                          status
);
	import mcc_pkg::*;

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(conv_sum) && $stable(status))
		else $error("result beat dropped or changed while stalled");

	// a flagged request carries a zero sum
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status |-> conv_sum == '0)
		else $error("flagged result with nonzero sum");

	// one request at a time: no accept right after an accept
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in flight");

	// a fresh result only comes out of a busy engine
	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("result appeared with no request in flight");

endmodule

bind multichannel_conv2d_engine mcc_checker u_mcc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.conv_sum  (rsp.conv_sum),
	.status    (rsp.status)
);

@@ tb/sv/multichannel_conv2d_engine_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_conv2d_engine_test: self-checking bench of the convolution engine
// Sends load and compute requests with random gaps and random result stalls.
// A shadow copy of the registers and stores works out each expected
// conv_sum and status. Every result beat is compared with the oldest one
// still waiting. Computes in range are sent only once their window is loaded.
// ----------------------------------------------------------------------------
module multichannel_conv2d_engine_test;
	import mcc_pkg::*;

	localparam int MAX_ROWS        = 64;
	localparam int MAX_COLS        = 64;
	localparam int MAX_KERNEL_ROWS = 8;
	localparam int MAX_KERNEL_COLS = 8;
	localparam int MAX_IN_PLANES   = 16;
	localparam int MAX_OUT_PLANES  = 16;
	localparam int SAMPLE_DEPTH    = MAX_IN_PLANES * MAX_ROWS * MAX_COLS;
	localparam int WEIGHT_DEPTH    = MAX_OUT_PLANES * MAX_IN_PLANES * MAX_KERNEL_ROWS
		* MAX_KERNEL_COLS;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEM_TARGET     = 500;
	localparam int DRAIN_CYCLES    = 64;

	typedef struct packed {
		logic [REQ_W-1:0]          kind;
		logic [IDX_W-1:0]          row;
		logic [IDX_W-1:0]          col;
		logic [PLANE_W-1:0]        src;
		logic [PLANE_W-1:0]        dst;
		logic signed [SHORT_W-1:0] value;
		logic signed [BIAS_W-1:0]  bias;
	} conv_req_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic                    status;
	} conv_res_t;

	class conv_shadow;
		logic [CFG_DATA_W-1:0]     regs [8];
		int                        h, w, kh, kw, dr, dc, np, nq, hout, wout;
		logic signed [SHORT_W-1:0] samples [SAMPLE_DEPTH];
		logic signed [SHORT_W-1:0] weights [WEIGHT_DEPTH];
		logic signed [BIAS_W-1:0]  biases [MAX_OUT_PLANES];
		bit                        sample_set [SAMPLE_DEPTH];
		bit                        weight_set [WEIGHT_DEPTH];
		bit                        bias_set [MAX_OUT_PLANES];
		conv_res_t                 pending [$];
		int                        mismatches;

		function new();
			foreach (regs[i]) regs[i] = 1;
			mismatches = 0;
			apply_limits();
		endfunction

		function int clamp(int v, int hi);
			if (v < 1) return 1;
			if (v > hi) return hi;
			return v;
		endfunction

		function void apply_limits();
			h  = clamp(regs[CFG_IN_HEIGHT], MAX_ROWS);
			w  = clamp(regs[CFG_IN_WIDTH], MAX_COLS);
			kh = clamp(regs[CFG_KERNEL_HEIGHT], MAX_KERNEL_ROWS);
			kw = clamp(regs[CFG_KERNEL_WIDTH], MAX_KERNEL_COLS);
			// a zero stride counts as one, no upper bound
			dr = clamp(regs[CFG_STRIDE_ROWS], 1 << SIZE_W);
			dc = clamp(regs[CFG_STRIDE_COLS], 1 << SIZE_W);
			np = clamp(regs[CFG_IN_PLANES], MAX_IN_PLANES);
			nq = clamp(regs[CFG_OUT_PLANES], MAX_OUT_PLANES);
			hout = (h >= kh) ? (h - kh) / dr + 1 : 0;
			wout = (w >= kw) ? (w - kw) / dc + 1 : 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			// kernel sizes and plane counts keep only their register width
			case (idx)
				CFG_KERNEL_HEIGHT, CFG_KERNEL_WIDTH: regs[idx] = data & 7'h0F;
				CFG_IN_PLANES, CFG_OUT_PLANES:       regs[idx] = data & 7'h1F;
				default:                             regs[idx] = data;
			endcase
			apply_limits();
		endfunction

		function int sample_index(int p, int r, int c);
			return (p * MAX_ROWS + r) * MAX_COLS + c;
		endfunction

		function int weight_index(int d, int p, int s, int t);
			return ((d * MAX_IN_PLANES + p) * MAX_KERNEL_ROWS + s) * MAX_KERNEL_COLS + t;
		endfunction

		function void take_request(conv_req_t r);
			conv_res_t res;
			longint    acc;
			int        p, s, t, k;
			res.sum = '0;
			res.status = 1'b0;
			case (r.kind)
				REQ_SAMPLE: begin
					res.status = r.row >= h || r.col >= w || r.src >= np;
					if (!res.status) begin
						k = sample_index(r.src, r.row, r.col);
						samples[k] = r.value;
						sample_set[k] = 1'b1;
					end
				end
				REQ_WEIGHT: begin
					res.status = r.row >= kh || r.col >= kw || r.src >= np || r.dst >= nq;
					if (!res.status) begin
						k = weight_index(r.dst, r.src, r.row, r.col);
						weights[k] = r.value;
						weight_set[k] = 1'b1;
					end
				end
				REQ_BIAS: begin
					res.status = r.dst >= nq;
					if (!res.status) begin
						biases[r.dst] = r.bias;
						bias_set[r.dst] = 1'b1;
					end
				end
				default: begin
					res.status = r.row >= hout || r.col >= wout || r.dst >= nq;
					if (!res.status) begin
						acc = biases[r.dst];
						for (p = 0; p < np; p++)
							for (s = 0; s < kh; s++)
								for (t = 0; t < kw; t++)
									acc += longint'(weights[weight_index(r.dst, p, s, t)])
										* longint'(samples[sample_index(p, dr * r.row + s,
										dc * r.col + t)]);
						res.sum = acc[SUM_W-1:0];
					end
				end
			endcase
			pending.push_back(res);
		endfunction

		function void match_result(logic signed [SUM_W-1:0] sum, logic status);
			conv_res_t want;
			if (pending.size() == 0) begin
				$error("result beat with nothing outstanding: conv_sum %0d status %0d",
					sum, status);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			if (status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, status);
				mismatches++;
			end
			if (sum !== want.sum) begin
				$error("conv_sum: expected %0d, got %0d", want.sum, sum);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	bit          idling = 1'b1;
	int unsigned cycles = 0;
	int          sent_items = 0;
	conv_shadow  shadow = new();

	mcc_req_if req_ch ();
	mcc_rsp_if rsp_ch ();
	mcc_cfg_if cfg_ch ();

	multichannel_conv2d_engine #(
		.MAX_ROWS        (MAX_ROWS),
		.MAX_COLS        (MAX_COLS),
		.MAX_KERNEL_ROWS (MAX_KERNEL_ROWS),
		.MAX_KERNEL_COLS (MAX_KERNEL_COLS),
		.MAX_IN_PLANES   (MAX_IN_PLANES),
		.MAX_OUT_PLANES  (MAX_OUT_PLANES)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			shadow.match_result(rsp_ch.conv_sum, rsp_ch.status);
	end

	// receiver: stall in random bursts while idling is on
	initial begin : result_stalls
		int hold;
		hold = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold == 0 && idling && $urandom_range(0, 7) == 0)
				hold = $urandom_range(1, 16);
			rsp_ch.ready = (hold == 0);
			if (hold > 0)
				hold--;
		end
	end

	function automatic conv_req_t make_req(logic [REQ_W-1:0] kind, int row, int col,
		int src, int dst, logic [SHORT_W-1:0] value, logic [BIAS_W-1:0] bias);
		conv_req_t r;
		r.kind  = kind;
		r.row   = row[IDX_W-1:0];
		r.col   = col[IDX_W-1:0];
		r.src   = src[PLANE_W-1:0];
		r.dst   = dst[PLANE_W-1:0];
		r.value = value;
		r.bias  = bias;
		return r;
	endfunction

	function automatic logic [SHORT_W-1:0] pick_short();
		case ($urandom_range(0, 7))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			default: return SHORT_W'($urandom);
		endcase
	endfunction

	// mostly inside the configured count, sometimes anywhere in the field
	function automatic int pick_index(int count, int span);
		if ($urandom_range(0, 3) != 0)
			return $urandom_range(0, count - 1);
		return $urandom_range(0, span - 1);
	endfunction

	task automatic send_req(conv_req_t r);
		int gap;
		if (idling && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 16);
			@(negedge clk) req_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid       = 1'b1;
		req_ch.req_type    = r.kind;
		req_ch.row_index   = r.row;
		req_ch.col_index   = r.col;
		req_ch.src_plane   = r.src;
		req_ch.dst_plane   = r.dst;
		req_ch.short_value = r.value;
		req_ch.bias_value  = r.bias;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		shadow.take_request(r);
		sent_items++;
	endtask

	task automatic release_req();
		@(negedge clk) req_ch.valid = 1'b0;
	endtask

	// vals are given in register index order
	task automatic load_config(input int vals [8]);
		int i;
		release_req();
		while (shadow.pending.size() != 0)
			@(posedge clk);
		for (i = CFG_IN_HEIGHT; i <= CFG_OUT_PLANES; i++) begin
			@(negedge clk);
			cfg_ch.valid = 1'b1;
			cfg_ch.index = i[CFG_IDX_W-1:0];
			cfg_ch.data  = vals[i][CFG_DATA_W-1:0];
			@(posedge clk);
			while (!cfg_ch.ready)
				@(posedge clk);
			shadow.write_register(cfg_ch.index, cfg_ch.data);
		end
		@(negedge clk) cfg_ch.valid = 1'b0;
	endtask

	// load whatever the window still lacks, then ask for the output element
	task automatic compute_at(int d, int r, int c);
		int p, s, t, row, col;
		if (!shadow.bias_set[d])
			send_req(make_req(REQ_BIAS, $urandom_range(0, 63), $urandom_range(0, 63),
				$urandom_range(0, 15), d, pick_short(), $urandom));
		for (p = 0; p < shadow.np; p++)
			for (s = 0; s < shadow.kh; s++)
				for (t = 0; t < shadow.kw; t++) begin
					row = shadow.dr * r + s;
					col = shadow.dc * c + t;
					if (!shadow.sample_set[shadow.sample_index(p, row, col)])
						send_req(make_req(REQ_SAMPLE, row, col, p, $urandom_range(0, 15),
							pick_short(), $urandom));
					if (!shadow.weight_set[shadow.weight_index(d, p, s, t)])
						send_req(make_req(REQ_WEIGHT, s, t, p, d, pick_short(), $urandom));
				end
		send_req(make_req(REQ_COMPUTE, r, c, $urandom_range(0, 15), d, pick_short(),
			$urandom));
	endtask

	task automatic random_config();
		int vals [8];
		vals[CFG_IN_HEIGHT]     = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
			: $urandom_range(1, 10);
		vals[CFG_IN_WIDTH]      = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
			: $urandom_range(1, 10);
		vals[CFG_KERNEL_HEIGHT] = $urandom_range(0, 4);
		vals[CFG_KERNEL_WIDTH]  = $urandom_range(0, 4);
		vals[CFG_STRIDE_ROWS]   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
			: $urandom_range(1, 3);
		vals[CFG_STRIDE_COLS]   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
			: $urandom_range(1, 3);
		vals[CFG_IN_PLANES]     = $urandom_range(0, 4);
		vals[CFG_OUT_PLANES]    = $urandom_range(0, 4);
		load_config(vals);
	endtask

	task automatic random_item();
		int roll, d, r, c;
		roll = $urandom_range(0, 99);
		if (roll < 40) begin
			if (shadow.hout > 0 && shadow.wout > 0)
				compute_at($urandom_range(0, shadow.nq - 1), $urandom_range(0, shadow.hout - 1),
					$urandom_range(0, shadow.wout - 1));
			else
				send_req(make_req(REQ_COMPUTE, $urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 15), $urandom_range(0, 15), pick_short(), $urandom));
		end else if (roll < 55) begin
			d = $urandom_range(0, 15);
			r = $urandom_range(0, 63);
			c = $urandom_range(0, 63);
			if (r < shadow.hout && c < shadow.wout && d < shadow.nq)
				compute_at(d, r, c);
			else
				send_req(make_req(REQ_COMPUTE, r, c, $urandom_range(0, 15), d, pick_short(),
					$urandom));
		end else if (roll < 72) begin
			send_req(make_req(REQ_SAMPLE, pick_index(shadow.h, 64), pick_index(shadow.w, 64),
				pick_index(shadow.np, 16), $urandom_range(0, 15), pick_short(), $urandom));
		end else if (roll < 89) begin
			send_req(make_req(REQ_WEIGHT, pick_index(shadow.kh, 64), pick_index(shadow.kw, 64),
				pick_index(shadow.np, 16), pick_index(shadow.nq, 16), pick_short(), $urandom));
		end else begin
			send_req(make_req(REQ_BIAS, $urandom_range(0, 63), $urandom_range(0, 63),
				$urandom_range(0, 15), pick_index(shadow.nq, 16), pick_short(), $urandom));
		end
	endtask

	initial begin : stimulus
		int ph, phase_end;
		req_ch.valid       = 1'b0;
		req_ch.req_type    = REQ_SAMPLE;
		req_ch.row_index   = '0;
		req_ch.col_index   = '0;
		req_ch.src_plane   = '0;
		req_ch.dst_plane   = '0;
		req_ch.short_value = '0;
		req_ch.bias_value  = '0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = CFG_IN_HEIGHT;
		cfg_ch.data        = '0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset settings: single tap, extreme values, flagged indexes
		send_req(make_req(REQ_BIAS, 0, 0, 0, 0, 16'h0000, 32'h7FFF_FFFF));
		send_req(make_req(REQ_SAMPLE, 0, 0, 0, 0, 16'h7FFF, 32'h0));
		send_req(make_req(REQ_WEIGHT, 0, 0, 0, 0, 16'h7FFF, 32'h0));
		send_req(make_req(REQ_COMPUTE, 0, 0, 0, 0, 16'h0, 32'h0));
		send_req(make_req(REQ_BIAS, 0, 0, 0, 0, 16'h0000, 32'h8000_0000));
		send_req(make_req(REQ_SAMPLE, 0, 0, 0, 0, 16'h8000, 32'h0));
		send_req(make_req(REQ_WEIGHT, 0, 0, 0, 0, 16'h8000, 32'h0));
		send_req(make_req(REQ_COMPUTE, 0, 0, 0, 0, 16'h0, 32'h0));
		send_req(make_req(REQ_SAMPLE, 63, 63, 15, 15, 16'hFFFF, 32'hFFFF_FFFF));
		send_req(make_req(REQ_WEIGHT, 0, 0, 0, 15, 16'h1234, 32'h0));
		send_req(make_req(REQ_BIAS, 0, 0, 0, 15, 16'h0, 32'h1234_5678));
		send_req(make_req(REQ_COMPUTE, 63, 63, 15, 15, 16'h0, 32'h0));
		send_req(make_req(REQ_COMPUTE, 1, 0, 0, 0, 16'h0, 32'h0));

		// values past their ranges saturate; kernel taller than input flags computes
		load_config('{0, 127, 15, 16, 0, 127, 31, 32});
		send_req(make_req(REQ_COMPUTE, 0, 0, 0, 0, 16'h0, 32'h0));
		send_req(make_req(REQ_SAMPLE, 0, 63, 15, 0, 16'h5A5A, 32'h0));
		send_req(make_req(REQ_WEIGHT, 7, 0, 15, 0, 16'hA5A5, 32'h0));
		send_req(make_req(REQ_WEIGHT, 7, 0, 15, 1, 16'hA5A5, 32'h0));

		// kernel wider than input
		load_config('{3, 2, 2, 4, 1, 1, 1, 1});
		send_req(make_req(REQ_COMPUTE, 0, 0, 0, 0, 16'h0, 32'h0));

		// largest kernel window on one plane; stores kept from earlier settings
		load_config('{64, 64, 8, 8, 64, 64, 1, 16});
		compute_at(15, 0, 0);
		compute_at(0, 0, 0);
		send_req(make_req(REQ_COMPUTE, 1, 0, 0, 0, 16'h0, 32'h0));

		// spread the remaining items over the random phases
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			idling = (ph < RANDOM_PHASES - 1);
			random_config();
			phase_end = sent_items + (ITEM_TARGET - sent_items) / (RANDOM_PHASES - ph);
			while (sent_items < phase_end)
				random_item();
		end

		release_req();
		while (shadow.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (shadow.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
